// File: rtl/bvo_pkg.sv
// Shared constants, types and helpers for the bounding-volume overlap test.
`timescale 1ns / 1ps
`default_nettype none

package bvo_pkg;

   // Coordinate lane width and the widths that follow from it.
   localparam int COORD_BITS = 16;
   localparam int XYZ_W      = 48;
   localparam int SUM_W      = COORD_BITS + 1;     // corner sums and differences
   localparam int DIF_W      = COORD_BITS + 2;     // doubled-unit offsets
   localparam int R2_W       = 2 * COORD_BITS + 2; // squared doubled radius
   localparam int D2_W       = 2 * COORD_BITS + 4; // squared doubled distance
   localparam int E_W        = 2 * COORD_BITS + 3; // signed plane cross term
   localparam int EA_W       = 2 * COORD_BITS + 2; // magnitude of the cross term
   localparam int N2_W       = 2 * COORD_BITS + 1; // squared plane normal length
   localparam int MUL_W      = D2_W;               // operand width of the wide multiplier
   localparam int HALF_W     = MUL_W / 2;
   localparam int PROD_W     = 2 * MUL_W;

   typedef enum logic [1:0] {
      KIND_SPHERE  = 2'd0,
      KIND_BOX     = 2'd1,
      KIND_TRIGGER = 2'd2,
      KIND_PLANE   = 2'd3
   } kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [DIF_W-1:0]      dif_type;

   // Results of the geometry front end, one transaction per cycle.
   typedef struct packed {
      logic                   valid;
      kind_type               a_kind;
      kind_type               b_kind;
      logic                   flat;
      logic [R2_W-1:0]        ra;
      logic [R2_W-1:0]        rb;
      logic [N2_W-1:0]        n2;
      logic [D2_W-1:0]        box_d2;
      logic [D2_W-1:0]        sph_d2;
      logic signed [E_W-1:0]  e;
   } front_out_type;

   // Decision bits that travel beside the wide multipliers.
   typedef struct packed {
      logic     valid;
      kind_type a_kind;
      kind_type b_kind;
      logic     flat;
      logic     box_hit;
      logic     sph_le;
   } ctl_type;

   // Extract one signed coordinate lane from a packed corner.
   function automatic coord_type lane(input logic [XYZ_W-1:0] xyz, input int idx);
      return coord_type'(xyz[idx*COORD_BITS +: COORD_BITS]);
   endfunction

endpackage

`default_nettype wire

// File: rtl/bvo_front.sv
// Geometry front end: centers, offsets, squares and sums in four stages.
`timescale 1ns / 1ps
`default_nettype none

module bvo_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [1:0]                a_kind,
   input  logic [bvo_pkg::XYZ_W-1:0] a_min_xyz,
   input  logic [bvo_pkg::XYZ_W-1:0] a_max_xyz,
   input  logic [1:0]                b_kind,
   input  logic [bvo_pkg::XYZ_W-1:0] b_min_xyz,
   input  logic [bvo_pkg::XYZ_W-1:0] b_max_xyz,
   output bvo_pkg::front_out_type    front_out
);
   import bvo_pkg::*;

   // Stage 1 registers: doubled centers and radius vectors.
   logic      v1_in, v1_ff;
   kind_type  ak1_in, ak1_ff, bk1_in, bk1_ff;
   sum_type   ca1_in [3], ca1_ff [3];
   sum_type   cb1_in [3], cb1_ff [3];
   sum_type   da1_in [3], da1_ff [3];
   sum_type   db1_in [3], db1_ff [3];
   coord_type bmin1_in [3], bmin1_ff [3];
   coord_type bmax1_in [3], bmax1_ff [3];

   // Stage 2 registers: per-axis offsets.
   logic      v2_in, v2_ff;
   kind_type  ak2_in, ak2_ff, bk2_in, bk2_ff;
   dif_type   bd2_in [3], bd2_ff [3];
   dif_type   sd2_in [3], sd2_ff [3];
   dif_type   wx2_in, wx2_ff, wz2_in, wz2_ff;
   sum_type   da2_in [3], da2_ff [3];
   sum_type   db2_in [3], db2_ff [3];

   // Stage 3 registers: squares and cross products.
   logic                   v3_in, v3_ff;
   kind_type               ak3_in, ak3_ff, bk3_in, bk3_ff;
   logic                   flat3_in, flat3_ff;
   logic [2*SUM_W-1:0]     rasq3_in [3], rasq3_ff [3];
   logic [2*SUM_W-1:0]     rbsq3_in [3], rbsq3_ff [3];
   logic [2*DIF_W-1:0]     bsq3_in [3], bsq3_ff [3];
   logic [2*DIF_W-1:0]     ssq3_in [3], ssq3_ff [3];
   logic signed [E_W-1:0]  pz3_in, pz3_ff, px3_in, px3_ff;

   // Stage 4 register: front end result.
   front_out_type out_in, out_ff;

   // Stage 1: unpack lanes, form corner sums and differences.
   always_comb begin
      coord_type amn, amx, bmn, bmx;
      v1_in  = in_valid;
      ak1_in = kind_type'(a_kind);
      bk1_in = kind_type'(b_kind);
      for (int i = 0; i < 3; i++) begin
         amn = lane(a_min_xyz, i);
         amx = lane(a_max_xyz, i);
         bmn = lane(b_min_xyz, i);
         bmx = lane(b_max_xyz, i);
         ca1_in[i]   = SUM_W'(amn) + SUM_W'(amx);
         cb1_in[i]   = SUM_W'(bmn) + SUM_W'(bmx);
         da1_in[i]   = SUM_W'(amx) - SUM_W'(amn);
         db1_in[i]   = SUM_W'(bmx) - SUM_W'(bmn);
         bmin1_in[i] = bmn;
         bmax1_in[i] = bmx;
      end
   end

   // Stage 2: clamp offsets to the box, center offsets, plane offsets.
   always_comb begin
      dif_type c, lo, hi;
      v2_in  = v1_ff;
      ak2_in = ak1_ff;
      bk2_in = bk1_ff;
      for (int i = 0; i < 3; i++) begin
         c  = DIF_W'(ca1_ff[i]);
         lo = DIF_W'(bmin1_ff[i]) <<< 1;
         hi = DIF_W'(bmax1_ff[i]) <<< 1;
         // Below min is tested first, so swapped corners behave as given.
         if (c < lo) begin
            bd2_in[i] = c - lo;
         end else if (c > hi) begin
            bd2_in[i] = c - hi;
         end else begin
            bd2_in[i] = '0;
         end
         sd2_in[i] = DIF_W'(cb1_ff[i]) - DIF_W'(ca1_ff[i]);
         da2_in[i] = da1_ff[i];
         db2_in[i] = db1_ff[i];
      end
      wx2_in = DIF_W'(ca1_ff[0]) - (DIF_W'(bmax1_ff[0]) <<< 1);
      wz2_in = DIF_W'(ca1_ff[2]) - (DIF_W'(bmax1_ff[2]) <<< 1);
   end

   // Stage 3: squares of every offset and the two plane cross products.
   always_comb begin
      v3_in    = v2_ff;
      ak3_in   = ak2_ff;
      bk3_in   = bk2_ff;
      flat3_in = (db2_ff[1] == '0);
      for (int i = 0; i < 3; i++) begin
         rasq3_in[i] = $unsigned((2*SUM_W)'(da2_ff[i]) * (2*SUM_W)'(da2_ff[i]));
         rbsq3_in[i] = $unsigned((2*SUM_W)'(db2_ff[i]) * (2*SUM_W)'(db2_ff[i]));
         bsq3_in[i]  = $unsigned((2*DIF_W)'(bd2_ff[i]) * (2*DIF_W)'(bd2_ff[i]));
         ssq3_in[i]  = $unsigned((2*DIF_W)'(sd2_ff[i]) * (2*DIF_W)'(sd2_ff[i]));
      end
      // The normal is (-dz, 0, dx) up to the factor dy, so e = wz*dx - wx*dz.
      pz3_in = E_W'(wz2_ff) * E_W'(db2_ff[0]);
      px3_in = E_W'(wx2_ff) * E_W'(db2_ff[2]);
   end

   // Stage 4: sum the squares into squared lengths.
   always_comb begin
      out_in.valid  = v3_ff;
      out_in.a_kind = ak3_ff;
      out_in.b_kind = bk3_ff;
      out_in.flat   = flat3_ff;
      out_in.ra     = R2_W'(rasq3_ff[0]) + R2_W'(rasq3_ff[1]) + R2_W'(rasq3_ff[2]);
      out_in.rb     = R2_W'(rbsq3_ff[0]) + R2_W'(rbsq3_ff[1]) + R2_W'(rbsq3_ff[2]);
      out_in.n2     = N2_W'(rbsq3_ff[0]) + N2_W'(rbsq3_ff[2]);
      out_in.box_d2 = D2_W'(bsq3_ff[0]) + D2_W'(bsq3_ff[1]) + D2_W'(bsq3_ff[2]);
      out_in.sph_d2 = D2_W'(ssq3_ff[0]) + D2_W'(ssq3_ff[1]) + D2_W'(ssq3_ff[2]);
      out_in.e      = pz3_ff - px3_ff;
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      ak1_ff   <= ak1_in;
      bk1_ff   <= bk1_in;
      ca1_ff   <= ca1_in;
      cb1_ff   <= cb1_in;
      da1_ff   <= da1_in;
      db1_ff   <= db1_in;
      bmin1_ff <= bmin1_in;
      bmax1_ff <= bmax1_in;

      ak2_ff   <= ak2_in;
      bk2_ff   <= bk2_in;
      bd2_ff   <= bd2_in;
      sd2_ff   <= sd2_in;
      wx2_ff   <= wx2_in;
      wz2_ff   <= wz2_in;
      da2_ff   <= da2_in;
      db2_ff   <= db2_in;

      ak3_ff   <= ak3_in;
      bk3_ff   <= bk3_in;
      flat3_ff <= flat3_in;
      rasq3_ff <= rasq3_in;
      rbsq3_ff <= rbsq3_in;
      bsq3_ff  <= bsq3_in;
      ssq3_ff  <= ssq3_in;
      pz3_ff   <= pz3_in;
      px3_ff   <= px3_in;

      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         out_ff <= out_in;
      end
   end

   assign front_out = out_ff;

endmodule

`default_nettype wire

// File: rtl/bvo_wide_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
`default_nettype none

module bvo_wide_mul (
   input  logic                       clock,
   input  logic [bvo_pkg::MUL_W-1:0]  op_a,
   input  logic [bvo_pkg::MUL_W-1:0]  op_b,
   output logic [bvo_pkg::PROD_W-1:0] product
);
   import bvo_pkg::*;

   logic [2*HALF_W-1:0] ll_in, ll_ff, lh_in, lh_ff, hl_in, hl_ff, hh_in, hh_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;

   // First stage: the four half-width partial products.
   always_comb begin
      ll_in = (2*HALF_W)'(op_a[HALF_W-1:0])     * (2*HALF_W)'(op_b[HALF_W-1:0]);
      lh_in = (2*HALF_W)'(op_a[HALF_W-1:0])     * (2*HALF_W)'(op_b[MUL_W-1:HALF_W]);
      hl_in = (2*HALF_W)'(op_a[MUL_W-1:HALF_W]) * (2*HALF_W)'(op_b[HALF_W-1:0]);
      hh_in = (2*HALF_W)'(op_a[MUL_W-1:HALF_W]) * (2*HALF_W)'(op_b[MUL_W-1:HALF_W]);
   end

   // Second stage: align and add the partial products.
   always_comb begin
      prod_in = {hh_ff, ll_ff}
              + (PROD_W'(lh_ff) << HALF_W)
              + (PROD_W'(hl_ff) << HALF_W);
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

// File: rtl/bounding_volume_overlap_test.sv
// Top level of the sphere versus box, trigger, plane or sphere overlap pipeline.
//
//   Channel   Ports                                   Handshake
//   request   req_a_kind .. req_b_max_xyz             start high and busy low
//   response  rsp_hit                                 rsp_valid, one cycle
//
// One transaction enters per clock cycle; busy is always low.
// The hit result appears on rsp_valid once the request is taken and has passed
// four front end stages, two decision stages, two wide multiplier stages and
// the output register. The wide multipliers set the depth.
// Reset clears every valid bit; transactions in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module bounding_volume_overlap_test (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_a_kind,
   input  logic [bvo_pkg::XYZ_W-1:0] req_a_min_xyz,
   input  logic [bvo_pkg::XYZ_W-1:0] req_a_max_xyz,
   input  logic [1:0]                req_b_kind,
   input  logic [bvo_pkg::XYZ_W-1:0] req_b_min_xyz,
   input  logic [bvo_pkg::XYZ_W-1:0] req_b_max_xyz,
   output logic                      rsp_valid,
   output logic                      rsp_hit
);
   import bvo_pkg::*;

   typedef struct packed {
      logic               valid;
      kind_type           a_kind;
      kind_type           b_kind;
      logic               flat;
      logic               box_hit;
      logic [R2_W-1:0]    ra;
      logic [R2_W-1:0]    rb;
      logic [N2_W-1:0]    n2;
      logic [D2_W-1:0]    sph_d2;
      logic [R2_W:0]      rsum;
      logic [EA_W-1:0]    ea;
   } s5_type;

   typedef struct packed {
      logic               valid;
      kind_type           a_kind;
      kind_type           b_kind;
      logic               flat;
      logic               box_hit;
      logic               sph_le;
      logic [EA_W-1:0]    ea;
      logic [R2_W-1:0]    ra;
      logic [R2_W-1:0]    rb;
      logic [N2_W-1:0]    n2;
      logic [MUL_W-1:0]   t;
   } s6_type;

   logic              accept;
   front_out_type     front;
   s5_type            s5_in, s5_ff;
   s6_type            s6_in, s6_ff;
   ctl_type           c7_in, c7_ff, c8_ff;
   logic [PROD_W-1:0] plane_lhs, plane_rhs, sph_lhs, sph_rhs;
   logic              plane_hit, sph_hit, sel_hit;
   logic              rsp_valid_in, rsp_valid_ff, rsp_hit_in, rsp_hit_ff;

   // The pipeline never stalls, so every request transaction is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   bvo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a_kind    (req_a_kind),
      .a_min_xyz (req_a_min_xyz),
      .a_max_xyz (req_a_max_xyz),
      .b_kind    (req_b_kind),
      .b_min_xyz (req_b_min_xyz),
      .b_max_xyz (req_b_max_xyz),
      .front_out (front)
   );

   // Stage 5: box decision, radius sum and cross-term magnitude.
   always_comb begin
      s5_in.valid   = front.valid;
      s5_in.a_kind  = front.a_kind;
      s5_in.b_kind  = front.b_kind;
      s5_in.flat    = front.flat;
      s5_in.box_hit = (front.box_d2 <= D2_W'(front.ra));
      s5_in.ra      = front.ra;
      s5_in.rb      = front.rb;
      s5_in.n2      = front.n2;
      s5_in.sph_d2  = front.sph_d2;
      s5_in.rsum    = (R2_W+1)'(front.ra) + (R2_W+1)'(front.rb);
      s5_in.ea      = (front.e < 0) ? EA_W'(-front.e) : EA_W'(front.e);
   end

   // Stage 6: near sphere test and the excess over the radius sum.
   always_comb begin
      s6_in.valid   = s5_ff.valid;
      s6_in.a_kind  = s5_ff.a_kind;
      s6_in.b_kind  = s5_ff.b_kind;
      s6_in.flat    = s5_ff.flat;
      s6_in.box_hit = s5_ff.box_hit;
      s6_in.sph_le  = (s5_ff.sph_d2 <= D2_W'(s5_ff.rsum));
      s6_in.ea      = s5_ff.ea;
      s6_in.ra      = s5_ff.ra;
      s6_in.rb      = s5_ff.rb;
      s6_in.n2      = s5_ff.n2;
      s6_in.t       = MUL_W'(s5_ff.sph_d2 - D2_W'(s5_ff.rsum));
   end

   // Squared comparisons for the plane and far sphere cases.
   bvo_wide_mul u_plane_lhs (
      .clock   (clock),
      .op_a    (MUL_W'(s6_ff.ea)),
      .op_b    (MUL_W'(s6_ff.ea)),
      .product (plane_lhs)
   );

   bvo_wide_mul u_plane_rhs (
      .clock   (clock),
      .op_a    (MUL_W'(s6_ff.ra)),
      .op_b    (MUL_W'(s6_ff.n2)),
      .product (plane_rhs)
   );

   bvo_wide_mul u_sph_lhs (
      .clock   (clock),
      .op_a    (s6_ff.t),
      .op_b    (s6_ff.t),
      .product (sph_lhs)
   );

   bvo_wide_mul u_sph_rhs (
      .clock   (clock),
      .op_a    (MUL_W'(s6_ff.ra)),
      .op_b    (MUL_W'(s6_ff.rb)),
      .product (sph_rhs)
   );

   // Decision bits ride alongside the multipliers.
   always_comb begin
      c7_in.valid   = s6_ff.valid;
      c7_in.a_kind  = s6_ff.a_kind;
      c7_in.b_kind  = s6_ff.b_kind;
      c7_in.flat    = s6_ff.flat;
      c7_in.box_hit = s6_ff.box_hit;
      c7_in.sph_le  = s6_ff.sph_le;
   end

   // Output stage: finish the comparisons and pick the case by kind.
   always_comb begin
      plane_hit = c8_ff.flat || (plane_lhs <= plane_rhs);
      sph_hit   = c8_ff.sph_le || (sph_lhs <= (sph_rhs << 2));
      case (c8_ff.b_kind) inside
         KIND_BOX, KIND_TRIGGER: sel_hit = c8_ff.box_hit;
         KIND_PLANE:             sel_hit = plane_hit;
         default:                sel_hit = sph_hit;
      endcase
      rsp_valid_in = c8_ff.valid;
      rsp_hit_in   = (c8_ff.a_kind == KIND_SPHERE) && sel_hit;
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      if (reset) begin
         s5_ff.valid  <= 1'b0;
         s6_ff.valid  <= 1'b0;
         c7_ff.valid  <= 1'b0;
         c8_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         c7_ff        <= c7_in;
         c8_ff        <= c7_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

// File: verif/bounding_volume_overlap_test_tb.sv
// Self-checking testbench for the sphere versus box, trigger, plane or sphere overlap block.
`timescale 1ns / 1ps

// Predicts the hit bit of each accepted transaction and checks results in order.
class overlap_scoreboard;
   bit expected_hits[$];
   int errors;
   int checked;
   int hit_count;

   // Signed coordinate of one lane, widened for exact products.
   function longint coord_of(logic [bvo_pkg::XYZ_W-1:0] xyz, int idx);
      logic signed [bvo_pkg::COORD_BITS-1:0] v;
      longint widened;
      v = xyz[idx*bvo_pkg::COORD_BITS +: bvo_pkg::COORD_BITS];
      widened = longint'(v);
      return widened;
   endfunction

   // Overlap decision in doubled units, compared on squares.
   function bit predict_hit(logic [1:0] ak, logic [bvo_pkg::XYZ_W-1:0] amin_p,
                            logic [bvo_pkg::XYZ_W-1:0] amax_p, logic [1:0] bk,
                            logic [bvo_pkg::XYZ_W-1:0] bmin_p,
                            logic [bvo_pkg::XYZ_W-1:0] bmax_p);
      longint amin[3], amax[3], bmin[3], bmax[3], ca[3], cb[3];
      longint ra, rb, d, d2, lo, hi, uy, vx, vz, wx, wz, e, t;
      logic [127:0] mag, lhs, rhs, ra_w, n_w;
      ra = 0;
      rb = 0;
      for (int i = 0; i < 3; i++) begin
         amin[i] = coord_of(amin_p, i);
         amax[i] = coord_of(amax_p, i);
         bmin[i] = coord_of(bmin_p, i);
         bmax[i] = coord_of(bmax_p, i);
         ca[i] = amin[i] + amax[i];
         cb[i] = bmin[i] + bmax[i];
         d = amax[i] - amin[i];
         ra += d * d;
         d = bmax[i] - bmin[i];
         rb += d * d;
      end
      // Only a sphere as the first volume can report an overlap.
      if (ak != bvo_pkg::KIND_SPHERE) return 1'b0;
      case (bk)
         bvo_pkg::KIND_BOX, bvo_pkg::KIND_TRIGGER: begin
            // Squared distance from the center to the box, corners taken as given.
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
               lo = 2 * bmin[i];
               hi = 2 * bmax[i];
               if (ca[i] < lo) d2 += (ca[i] - lo) * (ca[i] - lo);
               else if (ca[i] > hi) d2 += (ca[i] - hi) * (ca[i] - hi);
            end
            return d2 <= ra;
         end
         bvo_pkg::KIND_PLANE: begin
            // A plane with no height span has a zero normal and always hits.
            uy = bmax[1] - bmin[1];
            if (uy == 0) return 1'b1;
            vx = bmin[0] - bmax[0];
            vz = bmin[2] - bmax[2];
            wx = ca[0] - 2 * bmax[0];
            wz = ca[2] - 2 * bmax[2];
            e = wx * vz - wz * vx;
            mag = 128'((e < 0) ? -e : e);
            lhs = mag * mag;
            ra_w = 128'(ra);
            n_w = 128'(vx * vx + vz * vz);
            rhs = ra_w * n_w;
            return lhs <= rhs;
         end
         default: begin
            // Sphere pair: d2 <= ra + rb + 2*sqrt(ra*rb), squared once more.
            d2 = 0;
            for (int i = 0; i < 3; i++) d2 += (cb[i] - ca[i]) * (cb[i] - ca[i]);
            if (d2 <= ra + rb) return 1'b1;
            t = d2 - ra - rb;
            mag = 128'(t);
            lhs = mag * mag;
            ra_w = 128'(ra);
            n_w = 128'(rb);
            rhs = (ra_w * n_w) << 2;
            return lhs <= rhs;
         end
      endcase
   endfunction

   function void note_request(logic [1:0] ak, logic [bvo_pkg::XYZ_W-1:0] amin_p,
                              logic [bvo_pkg::XYZ_W-1:0] amax_p, logic [1:0] bk,
                              logic [bvo_pkg::XYZ_W-1:0] bmin_p,
                              logic [bvo_pkg::XYZ_W-1:0] bmax_p);
      expected_hits.push_back(predict_hit(ak, amin_p, amax_p, bk, bmin_p, bmax_p));
   endfunction

   function void check_result(logic hit);
      bit want;
      if (expected_hits.size() == 0) begin
         $error("hit: result with no transaction pending, expected none, actual %0d", hit);
         errors++;
         return;
      end
      want = expected_hits.pop_front();
      checked++;
      if (hit === 1'b1) hit_count++;
      if (hit !== want) begin
         $error("hit mismatch: expected %0d, actual %0d", want, hit);
         errors++;
      end
   endfunction

   function int pending();
      return expected_hits.size();
   endfunction
endclass

module bounding_volume_overlap_test_tb;
   import bvo_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_CYCLES  = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_a_kind = '0;
   logic [XYZ_W-1:0]    req_a_min_xyz = '0;
   logic [XYZ_W-1:0]    req_a_max_xyz = '0;
   logic [1:0]          req_b_kind = '0;
   logic [XYZ_W-1:0]    req_b_min_xyz = '0;
   logic [XYZ_W-1:0]    req_b_max_xyz = '0;
   logic                rsp_valid;
   logic                rsp_hit;

   overlap_scoreboard   sb;
   int                  cycles = 0;
   int                  sent = 0;

   bounding_volume_overlap_test dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_a_kind(req_a_kind),
      .req_a_min_xyz(req_a_min_xyz),
      .req_a_max_xyz(req_a_max_xyz),
      .req_b_kind(req_b_kind),
      .req_b_min_xyz(req_b_min_xyz),
      .req_b_max_xyz(req_b_max_xyz),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results pending", cycles, sb.pending());
         $display("bounding_volume_overlap_test: mismatch");
         $finish;
      end
   end

   // Note every accepted transaction and check every result strobe.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_a_kind, req_a_min_xyz, req_a_max_xyz,
                            req_b_kind, req_b_min_xyz, req_b_max_xyz);
         if (rsp_valid) sb.check_result(rsp_hit);
      end
   end

   function automatic logic [XYZ_W-1:0] pack_xyz(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   // Present one pair and hold it until the block takes it.
   task automatic send_pair(logic [1:0] ak, logic [XYZ_W-1:0] amin, logic [XYZ_W-1:0] amax,
                            logic [1:0] bk, logic [XYZ_W-1:0] bmin, logic [XYZ_W-1:0] bmax);
      start         <= 1'b1;
      req_a_kind    <= ak;
      req_a_min_xyz <= amin;
      req_a_max_xyz <= amax;
      req_b_kind    <= bk;
      req_b_min_xyz <= bmin;
      req_b_max_xyz <= bmax;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold off until every expected result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // One random volume: mostly small well-formed boxes near the origin.
   task automatic random_volume(output logic [XYZ_W-1:0] vmin, output logic [XYZ_W-1:0] vmax);
      int mode, c, ext, lo[3], hi[3], tmp;
      int extremes[4];
      extremes = '{-32768, 32767, 0, -1};
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         vmin = XYZ_W'({$urandom, $urandom});
         vmax = XYZ_W'({$urandom, $urandom});
      end else if (mode == 2) begin
         vmin = pack_xyz(extremes[$urandom_range(0, 3)], extremes[$urandom_range(0, 3)],
                         extremes[$urandom_range(0, 3)]);
         vmax = pack_xyz(extremes[$urandom_range(0, 3)], extremes[$urandom_range(0, 3)],
                         extremes[$urandom_range(0, 3)]);
      end else begin
         for (int i = 0; i < 3; i++) begin
            c = int'($urandom_range(0, 80)) - 40;
            ext = $urandom_range(0, 12);
            lo[i] = c - ext;
            hi[i] = c + ext;
            if ($urandom_range(0, 11) == 0) begin
               tmp = lo[i];
               lo[i] = hi[i];
               hi[i] = tmp;
            end
         end
         vmin = pack_xyz(lo[0], lo[1], lo[2]);
         vmax = pack_xyz(hi[0], hi[1], hi[2]);
      end
   endtask

   initial begin
      logic [XYZ_W-1:0] amin, amax, bmin, bmax;
      logic [1:0] ak, bk;
      int burst_left;
      sb = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A first volume that is not a sphere never hits.
      send_pair(KIND_BOX, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_BOX, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0));
      send_pair(KIND_TRIGGER, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0));
      send_pair(KIND_PLANE, pack_xyz(0, 0, 0), pack_xyz(0, 0, 4),
                KIND_PLANE, pack_xyz(0, 0, 0), pack_xyz(10, 10, 0));
      // Sphere against box and trigger: overlap, exact touch, just apart.
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_BOX, pack_xyz(-1, -1, -1), pack_xyz(1, 1, 1));
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_BOX, pack_xyz(2, 0, 0), pack_xyz(5, 0, 0));
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_TRIGGER, pack_xyz(3, 0, 0), pack_xyz(5, 0, 0));
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_TRIGGER, pack_xyz(-5, 0, 0), pack_xyz(-2, 0, 0));
      // Box with swapped corners.
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_BOX, pack_xyz(5, 3, 3), pack_xyz(-5, -3, -3));
      send_pair(KIND_SPHERE, pack_xyz(8, 0, 0), pack_xyz(10, 0, 0),
                KIND_BOX, pack_xyz(5, 3, 3), pack_xyz(-5, -3, -3));
      // Sphere against plane z = 0: touching, apart, and a flat plane.
      send_pair(KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(0, 0, 4),
                KIND_PLANE, pack_xyz(0, 0, 0), pack_xyz(10, 10, 0));
      send_pair(KIND_SPHERE, pack_xyz(0, 0, 1), pack_xyz(0, 0, 5),
                KIND_PLANE, pack_xyz(0, 0, 0), pack_xyz(10, 10, 0));
      send_pair(KIND_SPHERE, pack_xyz(0, 0, 100), pack_xyz(0, 0, 101),
                KIND_PLANE, pack_xyz(0, 7, 0), pack_xyz(10, 7, 3));
      // Sphere against sphere: touching, just apart, overlapping.
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_SPHERE, pack_xyz(2, 0, 0), pack_xyz(6, 0, 0));
      send_pair(KIND_SPHERE, pack_xyz(-2, 0, 0), pack_xyz(2, 0, 0),
                KIND_SPHERE, pack_xyz(3, 0, 0), pack_xyz(7, 0, 0));
      send_pair(KIND_SPHERE, pack_xyz(-2, -2, -2), pack_xyz(2, 2, 2),
                KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(1, 1, 1));
      // Coordinate extremes on every kind of second volume.
      for (int k = 0; k < 4; k++)
         send_pair(KIND_SPHERE, pack_xyz(-32768, -32768, -32768), pack_xyz(32767, 32767, 32767),
                   2'(k), pack_xyz(32767, -32768, 32767), pack_xyz(-32768, 32767, -32768));
      for (int k = 0; k < 4; k++)
         send_pair(KIND_SPHERE, pack_xyz(32767, 32767, 32767), pack_xyz(32767, 32767, 32767),
                   2'(k), pack_xyz(-32768, -32768, -32768), pack_xyz(-32768, -1, -32768));
      send_pair(KIND_SPHERE, '1, '1, KIND_PLANE, '0, '1);
      send_pair(KIND_PLANE, '1, '1, KIND_PLANE, '1, '1);
      drain();

      // Random pairs in bursts with gaps; one full drain midway.
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain();
         ak = ($urandom_range(0, 99) < 85) ? KIND_SPHERE : 2'($urandom_range(0, 3));
         bk = 2'($urandom_range(0, 3));
         random_volume(amin, amax);
         random_volume(bmin, bmax);
         send_pair(ak, amin, amax, bk, bmin, bmax);
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 20);
         end
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d volume pairs (directed edge cases and random bursts); %0d results",
               sent, sb.checked);
      $display("checked, %0d hits and %0d misses, %0d errors",
               sb.hit_count, sb.checked - sb.hit_count, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("bounding_volume_overlap_test: match");
      end else begin
         $display("bounding_volume_overlap_test: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bvo_pkg.sv
rtl/bvo_front.sv
rtl/bvo_wide_mul.sv
rtl/bounding_volume_overlap_test.sv
verif/bounding_volume_overlap_test_tb.sv
